// File: rtl/core/ptbe_pkg.sv
// Shared types, constants and the bitplane gather function of the tile encoder.
`default_nettype none
package ptbe_pkg;

  localparam int TILE_ROWS  = 8;
  localparam int ROW_W      = $clog2(TILE_ROWS);
  localparam int PIX_W      = 8;
  localparam int ROW_PIXELS = 8;
  localparam int IDX_W      = 5;

  // Byte index of the last byte of a run, per mode.
  localparam logic [IDX_W-1:0] LAST_2BPP      = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_4BPP_ROW  = IDX_W'(1);
  localparam logic [IDX_W-1:0] LAST_4BPP_TILE = IDX_W'(2 + 2 * TILE_ROWS - 1);
  localparam logic [IDX_W-1:0] LAST_8BPP      = IDX_W'(ROW_PIXELS - 1);
  // First byte index that reads the upper-plane store.
  localparam logic [IDX_W-1:0] UPPER_BASE     = IDX_W'(2);

  localparam logic [ROW_W-1:0] FINAL_ROW = ROW_W'(TILE_ROWS - 1);

  typedef enum logic [1:0] {
    MODE_2BPP = 2'd0,
    MODE_4BPP = 2'd1,
    MODE_8BPP = 2'd2,
    MODE_NONE = 2'd3
  } depth_mode_t;

  typedef logic [PIX_W-1:0] byte_t;
  typedef logic [ROW_PIXELS-1:0][PIX_W-1:0] pix_row_t;

  // One row's work, as handed from the row packer to the sequencer.
  typedef struct packed {
    depth_mode_t      mode;
    logic             final_row;
    logic [ROW_W-1:0] row;
    pix_row_t         bytes;
    logic [15:0]      upper;
    logic [IDX_W-1:0] last_idx;
  } job_t;

  // Gather bit 'sel' of every pixel into one byte, pixel 0 at the MSB.
  function automatic byte_t plane_byte(pix_row_t pix, logic [2:0] sel);
    byte_t b;
    b = '0;
    for (int i = 0; i < ROW_PIXELS; i++) begin
      b[ROW_PIXELS-1-i] = pix[i][sel];
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/ptbe_if.sv
// Valid/ready channel interfaces for pixel rows, tile bytes and the mode register.
`default_nettype none
interface ptbe_pix_if;
  logic                    valid;
  logic                    ready;
  logic [ptbe_pkg::PIX_W-1:0] pixel_0;
  logic [ptbe_pkg::PIX_W-1:0] pixel_1;
  logic [ptbe_pkg::PIX_W-1:0] pixel_2;
  logic [ptbe_pkg::PIX_W-1:0] pixel_3;
  logic [ptbe_pkg::PIX_W-1:0] pixel_4;
  logic [ptbe_pkg::PIX_W-1:0] pixel_5;
  logic [ptbe_pkg::PIX_W-1:0] pixel_6;
  logic [ptbe_pkg::PIX_W-1:0] pixel_7;
  modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, input ready);
  modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                pixel_6, pixel_7, output ready);
endinterface

interface ptbe_byte_if;
  logic                    valid;
  logic                    ready;
  logic [ptbe_pkg::PIX_W-1:0] tile_byte;
  logic                    last_of_run;
  logic                    tile_end;
  modport source (output valid, tile_byte, last_of_run, tile_end, input ready);
  modport sink (input valid, tile_byte, last_of_run, tile_end, output ready);
endinterface

interface ptbe_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] depth_mode;
  modport source (output valid, depth_mode, input ready);
  modport sink (input valid, depth_mode, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ptbe_row_pack.sv
// Row packer: turns one pixel row into plane bytes or raw bytes plus the index of the run's last byte.
`default_nettype none
module ptbe_row_pack (
  input  ptbe_pkg::pix_row_t         pixels,
  input  ptbe_pkg::depth_mode_t      mode,
  input  logic [ptbe_pkg::ROW_W-1:0] row,
  output ptbe_pkg::job_t             job
);
  import ptbe_pkg::*;

  byte_t p0, p1, p2, p3;
  logic  final_row;

  assign p0 = plane_byte(pixels, 3'd0);
  assign p1 = plane_byte(pixels, 3'd1);
  assign p2 = plane_byte(pixels, 3'd2);
  assign p3 = plane_byte(pixels, 3'd3);
  assign final_row = (row == FINAL_ROW);

  always_comb begin
    job           = '0;
    job.mode      = mode;
    job.final_row = final_row;
    job.row       = row;
    job.upper     = {p3, p2};
    case (mode)
      MODE_8BPP: begin
        job.bytes    = pixels;
        job.last_idx = LAST_8BPP;
      end
      MODE_4BPP: begin
        job.bytes[0] = p0;
        job.bytes[1] = p1;
        job.last_idx = final_row ? LAST_4BPP_TILE : LAST_4BPP_ROW;
      end
      default: begin
        job.bytes[0] = p0;
        job.bytes[1] = p1;
        job.last_idx = LAST_2BPP;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ptbe_sequencer.sv
// Byte sequencer: holds one row's job, the upper-plane store and the output register.
`default_nettype none
module ptbe_sequencer (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  ptbe_pkg::job_t job_in,
  output logic           ready,
  ptbe_byte_if.source    tiles
);
  import ptbe_pkg::*;

  job_t             job;
  logic             job_valid;
  logic [IDX_W-1:0] idx;
  logic [15:0]      store [TILE_ROWS];

  byte_t            out_byte;
  logic             out_last;
  logic             out_tend;
  logic             out_valid;

  logic             move;
  logic             is_last;
  logic [IDX_W-1:0] entry;
  logic [15:0]      store_row;
  byte_t            cur_byte;

  assign move    = job_valid && (!out_valid || tiles.ready);
  assign is_last = (idx == job.last_idx);
  assign ready   = !job_valid || (move && is_last);

  assign entry     = idx - UPPER_BASE;
  assign store_row = store[entry[ROW_W:1]];

  always_comb begin
    if (job.mode == MODE_4BPP && idx >= UPPER_BASE) begin
      cur_byte = entry[0] ? store_row[15:8] : store_row[7:0];
    end else begin
      cur_byte = job.bytes[idx[2:0]];
    end
  end

  // Upper planes of a 4bpp row land in the store as soon as the row is taken.
  always_ff @(posedge clk) begin
    if (load && job_in.mode == MODE_4BPP) begin
      store[job_in.row] <= job_in.upper;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (move) begin
      if (is_last) begin
        job_valid <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_byte <= cur_byte;
      out_last <= is_last;
      out_tend <= is_last && job.final_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (tiles.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign tiles.valid       = out_valid;
  assign tiles.tile_byte   = out_byte;
  assign tiles.last_of_run = out_last;
  assign tiles.tile_end    = out_tend;

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> idx <= job.last_idx)
    else $error("byte index ran past end of run");

  a_tend_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_tend || out_last))
    else $error("tile end without end of run");

  a_run_done: assert property (@(posedge clk) disable iff (rst)
    (move && is_last && !load) |=> !job_valid)
    else $error("job still busy after its last byte");

  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (move && !is_last && !load) |=> idx == $past(idx) + IDX_W'(1))
    else $error("byte index did not advance");

endmodule
`default_nettype wire

// File: rtl/core/planar_tile_bitplane_encoder.sv
// Top level of the planar tile bitplane encoder.
// Takes one 8-pixel tile row per request and gives tile bytes one per cycle unless
// stalled: 2 bytes per row in 2bpp mode, 8 in 8bpp mode, and in 4bpp mode 2 bytes
// per row plus the 16 stored plane 2/3 bytes after the eighth row. Output rate is
// set by the single output byte register; the next row is taken in the same cycle
// the previous row's last byte moves into it, so rows flow without gaps. Rows sent
// while depth_mode is 3 are taken and dropped. The row counter wraps every eight
// kept rows and is not reset by a mode change; write depth_mode only when idle.
`default_nettype none
module planar_tile_bitplane_encoder (
  input  logic        clk,
  input  logic        rst,
  ptbe_cfg_if.sink    cfg,
  ptbe_pix_if.sink    pixels,
  ptbe_byte_if.source tiles
);
  import ptbe_pkg::*;

  depth_mode_t      depth_mode;
  logic [ROW_W-1:0] row_count;
  pix_row_t         pix_row;
  job_t             job;
  logic             seq_ready;
  logic             accept;
  logic             load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= MODE_4BPP;
    end else if (cfg.valid) begin
      depth_mode <= depth_mode_t'(cfg.depth_mode);
    end
  end

  assign pix_row = {pixels.pixel_7, pixels.pixel_6, pixels.pixel_5, pixels.pixel_4,
                    pixels.pixel_3, pixels.pixel_2, pixels.pixel_1, pixels.pixel_0};

  assign pixels.ready = seq_ready;
  assign accept       = pixels.valid && seq_ready;
  // Drop rows in the unused mode.
  assign load         = accept && (depth_mode != MODE_NONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
    end else if (load) begin
      row_count <= row_count + ROW_W'(1);
    end
  end

  ptbe_row_pack u_row_pack (
    .pixels (pix_row),
    .mode   (depth_mode),
    .row    (row_count),
    .job    (job)
  );

  ptbe_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .load   (load),
    .job_in (job),
    .ready  (seq_ready),
    .tiles  (tiles)
  );

endmodule
`default_nettype wire

// File: tb/sv/planar_tile_bitplane_encoder_test.sv
// Testbench for the planar tile bitplane encoder: random rows under handshake stress.
`timescale 1ns / 1ps
module planar_tile_bitplane_encoder_test;
  import ptbe_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    byte_t value;
    logic  last;
    logic  tend;
  } tile_out_t;

  // Predicts tile bytes from accepted rows and checks the byte stream in order.
  class tile_byte_scoreboard;
    depth_mode_t      mode;
    logic [ROW_W-1:0] row_pos;
    byte_t            upper_planes[2*TILE_ROWS];
    tile_out_t        expected_bytes[$];
    int               errors;

    function new();
      mode = MODE_4BPP;
      row_pos = '0;
      errors = 0;
      foreach (upper_planes[i]) upper_planes[i] = '0;
    endfunction

    function void set_mode(depth_mode_t m);
      mode = m;
    endfunction

    function byte_t gather_bit(pix_row_t pix, int bit_sel);
      byte_t acc;
      acc = '0;
      for (int i = 0; i < ROW_PIXELS; i++) acc = {acc[6:0], pix[i][bit_sel]};
      return acc;
    endfunction

    function void push(byte_t v, logic last, logic tend);
      tile_out_t e;
      e.value = v;
      e.last = last;
      e.tend = tend;
      expected_bytes.push_back(e);
    endfunction

    function void note_row(pix_row_t pix);
      logic final_row;
      final_row = (row_pos == FINAL_ROW);
      case (mode)
        MODE_2BPP: begin
          push(gather_bit(pix, 0), 1'b0, 1'b0);
          push(gather_bit(pix, 1), 1'b1, final_row);
        end
        MODE_4BPP: begin
          upper_planes[{row_pos, 1'b0}] = gather_bit(pix, 2);
          upper_planes[{row_pos, 1'b1}] = gather_bit(pix, 3);
          push(gather_bit(pix, 0), 1'b0, 1'b0);
          push(gather_bit(pix, 1), !final_row, 1'b0);
          if (final_row) begin
            for (int i = 0; i < 2*TILE_ROWS; i++)
              push(upper_planes[i], i == 2*TILE_ROWS-1, i == 2*TILE_ROWS-1);
          end
        end
        MODE_8BPP: begin
          for (int i = 0; i < ROW_PIXELS; i++)
            push(pix[i], i == ROW_PIXELS-1, (i == ROW_PIXELS-1) && final_row);
        end
        default: return;  // drop the row, keep the row position
      endcase
      row_pos = row_pos + 1'b1;
    endfunction

    function void check_byte(byte_t v, logic last, logic tend);
      tile_out_t e;
      if (expected_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected tile byte: expected none, got %h last %b end %b",
                 $time, v, last, tend);
        return;
      end
      e = expected_bytes.pop_front();
      if (e.value !== v || e.last !== last || e.tend !== tend) begin
        errors++;
        $display("%0t: tile byte mismatch: expected %h last %b end %b, got %h last %b end %b",
                 $time, e.value, e.last, e.tend, v, last, tend);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_count;
  int   send_idle_pct;
  int   recv_stall_pct;

  tile_byte_scoreboard sb;

  ptbe_cfg_if  cfg_ch();
  ptbe_pix_if  pix_ch();
  ptbe_byte_if byte_ch();

  planar_tile_bitplane_encoder uut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixels (pix_ch),
    .tiles  (byte_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Stall the byte channel at random.
  always @(negedge clk) begin
    byte_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready)
      sb.check_byte(byte_ch.tile_byte, byte_ch.last_of_run, byte_ch.tile_end);
  end

  task automatic send_row(pix_row_t pix);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pix_ch.valid   <= 1'b1;
    pix_ch.pixel_0 <= pix[0];
    pix_ch.pixel_1 <= pix[1];
    pix_ch.pixel_2 <= pix[2];
    pix_ch.pixel_3 <= pix[3];
    pix_ch.pixel_4 <= pix[4];
    pix_ch.pixel_5 <= pix[5];
    pix_ch.pixel_6 <= pix[6];
    pix_ch.pixel_7 <= pix[7];
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    sb.note_row(pix);
  endtask

  // Hold the row channel until every predicted byte has come out, then let the block settle.
  task automatic drain_bytes();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_depth(depth_mode_t m);
    drain_bytes();
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.depth_mode <= m;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.set_mode(m);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic pix_row_t rand_row();
    pix_row_t pix;
    int       style;
    style = $urandom_range(3);
    for (int i = 0; i < ROW_PIXELS; i++) begin
      case (style)
        0: pix[i] = 8'($urandom);
        1: pix[i] = 8'($urandom_range(15));
        2: pix[i] = $urandom_range(1) ? 8'hFF : 8'h00;
        default: pix[i] = 8'($urandom_range(3));
      endcase
    end
    return pix;
  endfunction

  function automatic pix_row_t walk_row(logic from_top);
    pix_row_t pix;
    for (int i = 0; i < ROW_PIXELS; i++) pix[i] = from_top ? (8'h80 >> i) : (8'h01 << i);
    return pix;
  endfunction

  depth_mode_t phase_modes[16] = '{MODE_2BPP, MODE_4BPP, MODE_8BPP, MODE_NONE,
                                   MODE_4BPP, MODE_2BPP, MODE_4BPP, MODE_8BPP,
                                   MODE_4BPP, MODE_2BPP, MODE_NONE, MODE_8BPP,
                                   MODE_4BPP, MODE_4BPP, MODE_2BPP, MODE_8BPP};
  int idle_profile[4][2] = '{'{0, 0}, '{46, 0}, '{0, 46}, '{33, 33}};

  initial begin
    int n_rows;
    sb = new();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.depth_mode = MODE_4BPP;
    pix_ch.valid = 1'b0;
    pix_ch.pixel_0 = '0;
    pix_ch.pixel_1 = '0;
    pix_ch.pixel_2 = '0;
    pix_ch.pixel_3 = '0;
    pix_ch.pixel_4 = '0;
    pix_ch.pixel_5 = '0;
    pix_ch.pixel_6 = '0;
    pix_ch.pixel_7 = '0;
    byte_ch.ready = 1'b1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset mode is 4bpp: one full tile first, so every upper-plane entry is written.
    send_row('0);
    send_row('1);
    send_row({8{8'h0F}});
    send_row({8{8'hF0}});
    send_row(walk_row(1'b0));
    send_row(walk_row(1'b1));
    send_row({4{8'h55, 8'hAA}});
    send_row(rand_row());

    // 2bpp with high index bits that must be dropped; leaves the tile mid-way.
    write_depth(MODE_2BPP);
    send_row({8{8'hFC}});
    send_row({8{8'h03}});
    send_row({4{8'h01, 8'h02}});
    write_depth(MODE_8BPP);
    send_row('1);
    send_row(walk_row(1'b0));
    // Unused mode: rows vanish without moving the row position.
    write_depth(MODE_NONE);
    send_row(rand_row());
    send_row('1);
    // Back to 4bpp mid-tile: the tile end sends the store as it stands.
    write_depth(MODE_4BPP);
    send_row({8{8'hF8}});
    send_row(rand_row());
    send_row(rand_row());

    for (int ph = 0; ph < 16; ph++) begin
      write_depth(phase_modes[ph]);
      send_idle_pct = idle_profile[ph % 4][0];
      recv_stall_pct = idle_profile[ph % 4][1];
      n_rows = (phase_modes[ph] == MODE_NONE) ? 6 : 22;
      for (int k = 0; k < n_rows; k++) begin
        send_row(rand_row());
        if (ph == 6 && k == 10) drain_bytes();
      end
    end

    drain_bytes();
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
